// ===== hw/rtl/sdof_pkg.sv =====
// Shared types, constants and the microcode table for the SDOF oscillator block.
// Used by sdof_core and sdof_oscillator_response_top; no dependencies.
package sdof_pkg;

    localparam int W     = 48;   // Q16.32 word
    localparam int ACC_W = 52;   // exact sum of a few saturated words
    localparam int NREG  = 8;
    localparam int OPC_W = 5;
    localparam int PC_W  = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_SIN   = 3'd0;
    localparam logic [2:0] CFG_COS   = 3'd1;
    localparam logic [2:0] CFG_WD    = 3'd2;
    localparam logic [2:0] CFG_DW    = 3'd3;
    localparam logic [2:0] CFG_W2I   = 3'd4;
    localparam logic [2:0] CFG_W2IDT = 3'd5;
    localparam logic [2:0] CFG_WDI   = 3'd6;
    localparam logic [2:0] CFG_RAMP  = 3'd7;

    localparam logic [W-1:0] COS_RESET = 48'h0001_0000_0000;

    // operand / destination codes
    localparam logic [OPC_W-1:0] OP_X        = 5'd0;
    localparam logic [OPC_W-1:0] OP_PREV     = 5'd1;
    localparam logic [OPC_W-1:0] OP_DISP     = 5'd2;
    localparam logic [OPC_W-1:0] OP_VEL      = 5'd3;
    localparam logic [OPC_W-1:0] OP_SN       = 5'd4;
    localparam logic [OPC_W-1:0] OP_CS       = 5'd5;
    localparam logic [OPC_W-1:0] OP_WD       = 5'd6;
    localparam logic [OPC_W-1:0] OP_DW       = 5'd7;
    localparam logic [OPC_W-1:0] OP_W2I      = 5'd8;
    localparam logic [OPC_W-1:0] OP_W2IDT    = 5'd9;
    localparam logic [OPC_W-1:0] OP_WDI      = 5'd10;
    localparam logic [OPC_W-1:0] OP_RAMP     = 5'd11;
    localparam logic [OPC_W-1:0] OP_DUG      = 5'd12;
    localparam logic [OPC_W-1:0] OP_GW2I     = 5'd13;
    localparam logic [OPC_W-1:0] OP_DUGW2I   = 5'd14;
    localparam logic [OPC_W-1:0] OP_DUGW2IDT = 5'd15;
    localparam logic [OPC_W-1:0] OP_RD       = 5'd16;
    localparam logic [OPC_W-1:0] OP_B        = 5'd17;
    localparam logic [OPC_W-1:0] OP_T        = 5'd18;
    localparam logic [OPC_W-1:0] OP_A        = 5'd19;
    localparam logic [OPC_W-1:0] OP_K1       = 5'd20;
    localparam logic [OPC_W-1:0] OP_K2       = 5'd21;
    localparam logic [OPC_W-1:0] OP_W2       = 5'd22;
    localparam logic [OPC_W-1:0] OP_M2DW     = 5'd23;
    localparam logic [OPC_W-1:0] OP_ACC      = 5'd24;

    localparam logic [PC_W-1:0] LAST_PC = 5'd30;

    typedef struct packed {
        logic             is_mul;
        logic [OPC_W-1:0] sel_a;
        logic [OPC_W-1:0] sel_b;
        logic             neg;
        logic             first;
        logic             last;
        logic [OPC_W-1:0] dest;
    } t_uop;

    function automatic t_uop mk(input logic m, input logic [OPC_W-1:0] a,
                                input logic [OPC_W-1:0] b, input logic n,
                                input logic f, input logic l,
                                input logic [OPC_W-1:0] d);
        t_uop u;
        u.is_mul = m; u.sel_a = a; u.sel_b = b;
        u.neg = n; u.first = f; u.last = l; u.dest = d;
        return u;
    endfunction

    // One row per step: a term (product or operand) added to or subtracted from the accumulator.
    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = mk(1'b0, OP_X,     OP_X,        1'b0, 1'b1, 1'b0, OP_X);
            5'd1:  u = mk(1'b0, OP_PREV,  OP_X,        1'b1, 1'b0, 1'b1, OP_DUG);
            5'd2:  u = mk(1'b1, OP_PREV,  OP_W2I,      1'b0, 1'b1, 1'b1, OP_GW2I);
            5'd3:  u = mk(1'b1, OP_DUG,   OP_W2I,      1'b0, 1'b1, 1'b1, OP_DUGW2I);
            5'd4:  u = mk(1'b1, OP_DUG,   OP_W2IDT,    1'b0, 1'b1, 1'b1, OP_DUGW2IDT);
            5'd5:  u = mk(1'b1, OP_RAMP,  OP_DUG,      1'b0, 1'b1, 1'b1, OP_RD);
            5'd6:  u = mk(1'b0, OP_DISP,  OP_X,        1'b0, 1'b1, 1'b0, OP_X);
            5'd7:  u = mk(1'b0, OP_GW2I,  OP_X,        1'b0, 1'b0, 1'b0, OP_X);
            5'd8:  u = mk(1'b0, OP_RD,    OP_X,        1'b1, 1'b0, 1'b1, OP_B);
            5'd9:  u = mk(1'b1, OP_DW,    OP_WDI,      1'b0, 1'b1, 1'b1, OP_T);
            5'd10: u = mk(1'b1, OP_WDI,   OP_VEL,      1'b0, 1'b1, 1'b0, OP_X);
            5'd11: u = mk(1'b1, OP_T,     OP_B,        1'b0, 1'b0, 1'b0, OP_X);
            5'd12: u = mk(1'b1, OP_WDI,   OP_DUGW2IDT, 1'b0, 1'b0, 1'b1, OP_A);
            5'd13: u = mk(1'b1, OP_A,     OP_SN,       1'b0, 1'b1, 1'b0, OP_X);
            5'd14: u = mk(1'b1, OP_B,     OP_CS,       1'b0, 1'b0, 1'b0, OP_X);
            5'd15: u = mk(1'b0, OP_RD,    OP_X,        1'b0, 1'b0, 1'b0, OP_X);
            5'd16: u = mk(1'b0, OP_GW2I,  OP_X,        1'b1, 1'b0, 1'b0, OP_X);
            5'd17: u = mk(1'b0, OP_DUGW2I, OP_X,       1'b1, 1'b0, 1'b1, OP_DISP);
            5'd18: u = mk(1'b1, OP_WD,    OP_CS,       1'b0, 1'b1, 1'b0, OP_X);
            5'd19: u = mk(1'b1, OP_DW,    OP_SN,       1'b1, 1'b0, 1'b1, OP_K1);
            5'd20: u = mk(1'b1, OP_WD,    OP_SN,       1'b0, 1'b1, 1'b0, OP_X);
            5'd21: u = mk(1'b1, OP_DW,    OP_CS,       1'b0, 1'b0, 1'b1, OP_K2);
            5'd22: u = mk(1'b1, OP_A,     OP_K1,       1'b0, 1'b1, 1'b0, OP_X);
            5'd23: u = mk(1'b1, OP_B,     OP_K2,       1'b1, 1'b0, 1'b0, OP_X);
            5'd24: u = mk(1'b0, OP_DUGW2IDT, OP_X,     1'b1, 1'b0, 1'b1, OP_VEL);
            5'd25: u = mk(1'b1, OP_WD,    OP_WD,       1'b0, 1'b1, 1'b0, OP_X);
            5'd26: u = mk(1'b1, OP_DW,    OP_DW,       1'b0, 1'b0, 1'b1, OP_W2);
            5'd27: u = mk(1'b0, OP_DW,    OP_X,        1'b1, 1'b1, 1'b0, OP_X);
            5'd28: u = mk(1'b0, OP_DW,    OP_X,        1'b1, 1'b0, 1'b1, OP_M2DW);
            5'd29: u = mk(1'b1, OP_M2DW,  OP_VEL,      1'b0, 1'b1, 1'b0, OP_X);
            5'd30: u = mk(1'b1, OP_W2,    OP_DISP,     1'b1, 1'b0, 1'b1, OP_ACC);
            default: u = mk(1'b0, OP_X, OP_X, 1'b0, 1'b0, 1'b0, OP_X);
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/sdof_mul.sv =====
// Iterative Q16.32 multiplier: four 24x24 partial products, then round and saturate.
// Standalone; no package use.
module sdof_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [47:0] i_a,
    input  logic signed [47:0] i_b,
    output logic               o_done,
    output logic signed [47:0] o_prod,
    output logic               o_clip
);
    logic [47:0] r_ma, r_mb;
    logic        r_neg;
    logic [95:0] r_acc;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic signed [47:0] r_prod;
    logic        r_clip;

    logic [23:0] w_ha, w_hb;
    logic [47:0] w_pp;
    logic [95:0] w_pp_sh;
    logic [95:0] w_rsum;
    logic [63:0] w_rnd;
    logic signed [47:0] w_res;
    logic        w_clip;

    // partial product selected by the step count
    always_comb begin
        w_ha = r_cnt[0] ? r_ma[47:24] : r_ma[23:0];
        w_hb = r_cnt[1] ? r_mb[47:24] : r_mb[23:0];
        w_pp = w_ha * w_hb;
        case ({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]})
            2'd0:    w_pp_sh = {48'd0, w_pp};
            2'd1:    w_pp_sh = {24'd0, w_pp, 24'd0};
            default: w_pp_sh = {w_pp, 48'd0};
        endcase
    end

    // round half away from zero on the magnitude, then clip
    always_comb begin
        w_rsum = r_acc + 96'h8000_0000;
        w_rnd  = w_rsum[95:32];
        w_clip = 1'b0;
        if (r_neg) begin
            if (w_rnd > 64'h0000_8000_0000_0000) begin
                w_clip = 1'b1;
                w_res  = 48'sh8000_0000_0000;
            end else begin
                w_res  = -$signed(w_rnd[47:0]);
            end
        end else begin
            if (w_rnd > 64'h0000_7FFF_FFFF_FFFF) begin
                w_clip = 1'b1;
                w_res  = 48'sh7FFF_FFFF_FFFF;
            end else begin
                w_res  = $signed(w_rnd[47:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= i_a[47] ? 48'(-i_a) : i_a;
                r_mb   <= i_b[47] ? 48'(-i_b) : i_b;
                r_neg  <= i_a[47] ^ i_b[47];
                r_acc  <= 96'd0;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_prod <= w_res;
                    r_clip <= w_clip;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc <= r_acc + w_pp_sh;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    assign o_clip = r_clip;

endmodule

// ===== hw/rtl/sdof_core.sv =====
// Microcoded sequencer, accumulator and state registers of the SDOF solver.
// Uses sdof_pkg (codes, microcode table) and sdof_mul.
module sdof_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0][47:0]     i_cfg,
    input  logic                 i_in_valid,
    input  logic                 i_record_start,
    input  logic signed [47:0]   i_sample,
    output logic                 o_in_ready,
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output logic signed [47:0]   o_disp,
    output logic signed [47:0]   o_vel,
    output logic signed [47:0]   o_acc,
    output logic                 o_clip
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_MWAIT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam int AW = sdof_pkg::ACC_W;

    logic [1:0] r_state;
    logic [sdof_pkg::PC_W-1:0] r_pc;
    logic       r_have_prev;
    logic       r_clip;
    logic signed [AW-1:0] r_acc;
    logic signed [47:0] r_x, r_prev, r_disp, r_vel;
    logic signed [47:0] r_dug, r_gw2i, r_dugw2i, r_dugw2idt, r_rd, r_b, r_t;
    logic signed [47:0] r_a, r_k1, r_k2, r_w2, r_m2dw, r_accres;

    sdof_pkg::t_uop w_uop;
    logic signed [47:0] w_ops [32];
    logic       w_mul_start, w_mul_done, w_mul_clip;
    logic signed [47:0] w_mul_prod;
    logic       w_step;
    logic signed [47:0] w_term;
    logic signed [AW-1:0] w_base, w_sum;
    logic signed [47:0] w_sat;
    logic       w_sat_clip, w_term_clip;

    assign w_uop = sdof_pkg::uop_at(r_pc);

    // operand bus
    always_comb begin
        for (int i = 0; i < 32; i++) w_ops[i] = 48'sd0;
        w_ops[sdof_pkg::OP_X]        = r_x;
        w_ops[sdof_pkg::OP_PREV]     = r_prev;
        w_ops[sdof_pkg::OP_DISP]     = r_disp;
        w_ops[sdof_pkg::OP_VEL]      = r_vel;
        w_ops[sdof_pkg::OP_SN]       = $signed(i_cfg[sdof_pkg::CFG_SIN]);
        w_ops[sdof_pkg::OP_CS]       = $signed(i_cfg[sdof_pkg::CFG_COS]);
        w_ops[sdof_pkg::OP_WD]       = $signed(i_cfg[sdof_pkg::CFG_WD]);
        w_ops[sdof_pkg::OP_DW]       = $signed(i_cfg[sdof_pkg::CFG_DW]);
        w_ops[sdof_pkg::OP_W2I]      = $signed(i_cfg[sdof_pkg::CFG_W2I]);
        w_ops[sdof_pkg::OP_W2IDT]    = $signed(i_cfg[sdof_pkg::CFG_W2IDT]);
        w_ops[sdof_pkg::OP_WDI]      = $signed(i_cfg[sdof_pkg::CFG_WDI]);
        w_ops[sdof_pkg::OP_RAMP]     = $signed(i_cfg[sdof_pkg::CFG_RAMP]);
        w_ops[sdof_pkg::OP_DUG]      = r_dug;
        w_ops[sdof_pkg::OP_GW2I]     = r_gw2i;
        w_ops[sdof_pkg::OP_DUGW2I]   = r_dugw2i;
        w_ops[sdof_pkg::OP_DUGW2IDT] = r_dugw2idt;
        w_ops[sdof_pkg::OP_RD]       = r_rd;
        w_ops[sdof_pkg::OP_B]        = r_b;
        w_ops[sdof_pkg::OP_T]        = r_t;
        w_ops[sdof_pkg::OP_A]        = r_a;
        w_ops[sdof_pkg::OP_K1]       = r_k1;
        w_ops[sdof_pkg::OP_K2]       = r_k2;
        w_ops[sdof_pkg::OP_W2]       = r_w2;
        w_ops[sdof_pkg::OP_M2DW]     = r_m2dw;
        w_ops[sdof_pkg::OP_ACC]      = r_accres;
    end

    assign w_mul_start = (r_state == S_RUN) && w_uop.is_mul;

    sdof_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ops[w_uop.sel_a]),
        .i_b     (w_ops[w_uop.sel_b]),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod),
        .o_clip  (w_mul_clip)
    );

    // accumulate one term, saturate on the closing step
    always_comb begin
        w_step      = ((r_state == S_RUN) && !w_uop.is_mul) ||
                      ((r_state == S_MWAIT) && w_mul_done);
        w_term      = w_uop.is_mul ? w_mul_prod : w_ops[w_uop.sel_a];
        w_term_clip = w_uop.is_mul && w_mul_clip;
        w_base      = w_uop.first ? '0 : r_acc;
        w_sum       = w_uop.neg ? (w_base - AW'(w_term)) : (w_base + AW'(w_term));
        w_sat_clip  = 1'b0;
        w_sat       = w_sum[47:0];
        if (w_sum > AW'(48'sh7FFF_FFFF_FFFF)) begin
            w_sat      = 48'sh7FFF_FFFF_FFFF;
            w_sat_clip = 1'b1;
        end else if (w_sum < AW'(48'sh8000_0000_0000)) begin
            w_sat      = 48'sh8000_0000_0000;
            w_sat_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_have_prev <= 1'b0;
            r_prev      <= 48'sd0;
            r_disp      <= 48'sd0;
            r_vel       <= 48'sd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_record_start || !r_have_prev) begin
                            r_prev      <= i_sample;
                            r_disp      <= 48'sd0;
                            r_vel       <= 48'sd0;
                            r_have_prev <= 1'b1;
                        end else begin
                            r_x     <= i_sample;
                            r_pc    <= '0;
                            r_clip  <= 1'b0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_uop.is_mul) begin
                        r_state <= S_MWAIT;
                    end else if (r_pc == sdof_pkg::LAST_PC) begin
                        r_state <= S_FIN;
                    end
                end
                S_MWAIT: begin
                    if (w_mul_done) begin
                        r_state <= (r_pc == sdof_pkg::LAST_PC) ? S_FIN : S_RUN;
                    end
                end
                S_FIN: begin
                    if (i_res_take) begin
                        r_prev  <= r_x;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_step) begin
                if (w_term_clip || (w_uop.last && w_sat_clip)) r_clip <= 1'b1;
                if (w_uop.last) begin
                    case (w_uop.dest)
                        sdof_pkg::OP_DUG:      r_dug      <= w_sat;
                        sdof_pkg::OP_GW2I:     r_gw2i     <= w_sat;
                        sdof_pkg::OP_DUGW2I:   r_dugw2i   <= w_sat;
                        sdof_pkg::OP_DUGW2IDT: r_dugw2idt <= w_sat;
                        sdof_pkg::OP_RD:       r_rd       <= w_sat;
                        sdof_pkg::OP_B:        r_b        <= w_sat;
                        sdof_pkg::OP_T:        r_t        <= w_sat;
                        sdof_pkg::OP_A:        r_a        <= w_sat;
                        sdof_pkg::OP_DISP:     r_disp     <= w_sat;
                        sdof_pkg::OP_K1:       r_k1       <= w_sat;
                        sdof_pkg::OP_K2:       r_k2       <= w_sat;
                        sdof_pkg::OP_VEL:      r_vel      <= w_sat;
                        sdof_pkg::OP_W2:       r_w2       <= w_sat;
                        sdof_pkg::OP_M2DW:     r_m2dw     <= w_sat;
                        sdof_pkg::OP_ACC:      r_accres   <= w_sat;
                        default: ;
                    endcase
                end else begin
                    r_acc <= w_sum;
                end
                if (r_pc != sdof_pkg::LAST_PC) begin
                    r_pc <= r_pc + 1'b1;
                end
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_disp      = r_disp;
    assign o_vel       = r_vel;
    assign o_acc       = r_accres;
    assign o_clip      = r_clip;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier finished outside its wait state");
    a_fin_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_pc == sdof_pkg::LAST_PC))
        else $error("result shown before the last microcode step");
    a_reset_rest: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_have_prev)
        else $error("held sample survived reset");
`endif

endmodule

// ===== hw/rtl/sdof_oscillator_response_top.sv =====
// Each sample runs 31 microcode steps in order (20 multiplies, all on the one shared multiplier, and
// 11 adds); the result beat is then registered in the output beat register.
// A new sample is accepted only once the previous result is taken; a first sample of a record is only held.
// Reset (synchronous, active low) returns coefficients to defaults and the oscillator to rest.
// Top level: stream ports, configuration registers and output register.
// Uses sdof_pkg and sdof_core.
module sdof_oscillator_response_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // [47:0] accel_sample
    input  logic          s_axis_tuser,   // [0] record_start
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata,   // [47:0] displacement, [95:48] velocity,
                                          // [143:96] acceleration
    output logic          m_axis_tuser,   // [0] saturated
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [47:0]   i_cfg_data
);
    logic [7:0][47:0] r_cfg;
    logic             r_m_valid;
    logic [143:0]     r_m_data;
    logic             r_m_user;

    logic             w_in_ready, w_res_valid, w_take, w_clip;
    logic signed [47:0] w_disp, w_vel, w_acc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sdof_pkg::NREG; i++) begin
                r_cfg[i] <= (i == int'(sdof_pkg::CFG_COS)) ? sdof_pkg::COS_RESET : '0;
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    sdof_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (s_axis_tvalid),
        .i_record_start (s_axis_tuser),
        .i_sample       ($signed(s_axis_tdata)),
        .o_in_ready     (w_in_ready),
        .o_res_valid    (w_res_valid),
        .i_res_take     (w_take),
        .o_disp         (w_disp),
        .o_vel          (w_vel),
        .o_acc          (w_acc),
        .o_clip         (w_clip)
    );

    assign s_axis_tready = w_in_ready;
    assign w_take = w_res_valid && (!r_m_valid || m_axis_tready);

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {w_acc, w_vel, w_disp};
                r_m_user  <= w_clip;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for sdof_oscillator_response_top: stream stimulus, config writes
// and a cycle-free Q16.32 model of the oscillator step. Depends on sdof_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam longint MAXQ = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MINQ = -MAXQ - 1;
    localparam int SETTLE = 150;   // about the full microcode sequence of one sample

    typedef struct {
        longint disp;
        longint vel;
        longint acc;
        bit     clipped;
    } t_resp;

    typedef struct {
        bit     start;
        longint sample;
        bit     typed;
        t_resp  resp;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [47:0]   s_axis_tdata;    // [47:0] accel_sample
    logic          s_axis_tuser;    // [0] record_start
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [143:0]  m_axis_tdata;    // [47:0] displacement, [95:48] velocity, [143:96] accel
    logic          m_axis_tuser;    // [0] saturated
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index;
    logic [47:0]   i_cfg_data;

    sdof_oscillator_response_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // model state and coefficients
    longint coef [sdof_pkg::NREG];
    longint held_sample, disp_q, vel_q;
    bit     have_sample;
    bit     clip_seen;
    t_resp  pending_resp [$];
    int     errors;
    int     tx_idle, rx_idle;

    // typed expectation travels beside the beat
    bit     beat_typed;
    t_resp  beat_resp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint sat48(input longint v);
        if (v > MAXQ) begin
            clip_seen = 1'b1;
            return MAXQ;
        end
        if (v < MINQ) begin
            clip_seen = 1'b1;
            return MINQ;
        end
        return v;
    endfunction

    // Q16.32 product, half away from zero, then clipped
    function automatic longint qmul(input longint x, input longint y);
        logic [95:0] ax, ay, p;
        bit neg;
        neg = (x < 0) != (y < 0);
        ax = (x < 0) ? 96'(-x) : 96'(x);
        ay = (y < 0) ? 96'(-y) : 96'(y);
        p = ((ax * ay) + 96'h8000_0000) >> 32;
        if (neg) begin
            if (p > 96'h8000_0000_0000) begin
                clip_seen = 1'b1;
                return MINQ;
            end
            return -longint'(p);
        end
        if (p > 96'(MAXQ)) begin
            clip_seen = 1'b1;
            return MAXQ;
        end
        return longint'(p);
    endfunction

    function automatic longint sx48(input logic [47:0] u);
        return longint'($signed(u));
    endfunction

    // advance the oscillator by one interval; returns 1 when a response is due
    function automatic bit oscillator_step(input bit start, input longint x,
                                           output t_resp r);
        longint sn, cs, wd, dw, w2i, w2idt, wdi, ramp;
        longint dug, gw2i, dugw2i, dugw2idt, rd, b, a, d, v, w2, ac, k1, k2;
        sn = coef[sdof_pkg::CFG_SIN];   cs = coef[sdof_pkg::CFG_COS];
        wd = coef[sdof_pkg::CFG_WD];    dw = coef[sdof_pkg::CFG_DW];
        w2i = coef[sdof_pkg::CFG_W2I];  w2idt = coef[sdof_pkg::CFG_W2IDT];
        wdi = coef[sdof_pkg::CFG_WDI];  ramp = coef[sdof_pkg::CFG_RAMP];
        r = '{0, 0, 0, 0};
        if (start || !have_sample) begin
            held_sample = x;
            disp_q = 0;
            vel_q = 0;
            have_sample = 1'b1;
            return 1'b0;
        end
        clip_seen = 1'b0;
        dug = sat48(x - held_sample);
        gw2i = qmul(held_sample, w2i);
        dugw2i = qmul(dug, w2i);
        dugw2idt = qmul(dug, w2idt);
        rd = qmul(ramp, dug);
        b = sat48(disp_q + gw2i - rd);
        a = sat48(qmul(wdi, vel_q) + qmul(qmul(dw, wdi), b) + qmul(wdi, dugw2idt));
        d = sat48(qmul(a, sn) + qmul(b, cs) + rd - gw2i - dugw2i);
        k1 = sat48(qmul(wd, cs) - qmul(dw, sn));
        k2 = sat48(qmul(wd, sn) + qmul(dw, cs));
        v = sat48(qmul(a, k1) - qmul(b, k2) - dugw2idt);
        w2 = sat48(qmul(wd, wd) + qmul(dw, dw));
        ac = sat48(qmul(sat48(-2 * dw), v) - qmul(w2, d));
        disp_q = d;
        vel_q = v;
        held_sample = x;
        r = '{d, v, ac, clip_seen};
        return 1'b1;
    endfunction

    // monitor: sample both handshakes mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        t_resp r, e, got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (oscillator_step(s_axis_tuser, sx48(s_axis_tdata), r))
                pending_resp.push_back(beat_typed ? beat_resp : r);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{sx48(m_axis_tdata[47:0]), sx48(m_axis_tdata[95:48]),
                    sx48(m_axis_tdata[143:96]), m_axis_tuser};
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected result beat d=%0d v=%0d a=%0d sat=%0b",
                         $time, got.disp, got.vel, got.acc, got.clipped);
                errors++;
            end else begin
                e = pending_resp.pop_front();
                if (got.disp != e.disp) begin
                    $display("%0t: displacement exp %0d got %0d", $time, e.disp, got.disp);
                    errors++;
                end
                if (got.vel != e.vel) begin
                    $display("%0t: velocity exp %0d got %0d", $time, e.vel, got.vel);
                    errors++;
                end
                if (got.acc != e.acc) begin
                    $display("%0t: acceleration exp %0d got %0d", $time, e.acc, got.acc);
                    errors++;
                end
                if (got.clipped != e.clipped) begin
                    $display("%0t: saturated exp %0b got %0b", $time, e.clipped,
                             got.clipped);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle);

    // one sample beat; valid stays high into the next beat unless a gap is drawn
    task automatic send_sample(input bit start, input longint x, input bit typed,
                               input t_resp r);
        bit rdy;
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= x[47:0];
        beat_typed    <= typed;
        beat_resp     <= r;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        bit rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[47:0];
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        if (i_rst_n) coef[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // let the block drain before touching registers
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic longint to_q(input real r);
        return longint'(r * 4294967296.0);
    endfunction

    function automatic longint rand_sample;
        longint t;
        logic [63:0] u;
        case ($urandom_range(9)) inside
            0: return MAXQ;
            1: return MINQ;
            2, 3: begin
                u = {$urandom, $urandom};
                return sx48(u[47:0]);
            end
            default: begin
                t = longint'($signed($urandom));
                return t <<< $urandom_range(6);
            end
        endcase
    endfunction

    function automatic t_row mkrow(input bit s, input longint x, input bit t, input bit c);
        t_row r;
        r.start = s;
        r.sample = x;
        r.typed = t;
        r.resp = '{0, 0, 0, c};
        return r;
    endfunction

    initial begin
        t_row   dir_rows [$];
        t_resp  none;
        real    w, z, dt, wd, dw, e;
        longint cset [sdof_pkg::NREG];
        int     n, len;

        none = '{0, 0, 0, 0};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        beat_typed = 1'b0; beat_resp = none;
        errors = 0; tx_idle = 12; rx_idle = 65;
        foreach (coef[i]) coef[i] = 0;
        coef[sdof_pkg::CFG_COS] = 64'sh1_0000_0000;
        held_sample = 0; disp_q = 0; vel_q = 0; have_sample = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default coefficients give all-zero responses; only the input difference clips
        dir_rows.push_back(mkrow(0, 0, 1, 0));          // first since reset, no result
        dir_rows.push_back(mkrow(0, MAXQ, 1, 0));
        dir_rows.push_back(mkrow(0, MINQ, 1, 1));
        dir_rows.push_back(mkrow(0, MAXQ, 1, 1));
        dir_rows.push_back(mkrow(0, MINQ, 1, 1));
        dir_rows.push_back(mkrow(0, 0, 1, 1));
        dir_rows.push_back(mkrow(0, -1, 1, 0));
        dir_rows.push_back(mkrow(1, 12345, 1, 0));      // start mid-record
        dir_rows.push_back(mkrow(1, MINQ, 1, 0));       // back-to-back starts
        dir_rows.push_back(mkrow(0, MAXQ, 1, 1));
        dir_rows.push_back(mkrow(0, 64'sh1_0000_0000, 1, 0));
        dir_rows.push_back(mkrow(0, -64'sh3_8000_0000, 0, 0));
        dir_rows.push_back(mkrow(1, 64'sh2_0000_0000, 0, 0)); // one-sample record
        dir_rows.push_back(mkrow(1, -7, 0, 0));
        dir_rows.push_back(mkrow(0, 64'sh7FFF_0000_0001, 0, 0));
        foreach (dir_rows[i])
            send_sample(dir_rows[i].start, dir_rows[i].sample, dir_rows[i].typed,
                        dir_rows[i].resp);

        // a damped 2 Hz oscillator sampled at 100 Hz
        w = 2.0 * 3.14159265358979 * 2.0; z = 0.05; dt = 0.01;
        wd = w * $sqrt(1.0 - z * z); dw = z * w; e = $exp(-dw * dt);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph) inside
                0, 5: begin
                    cset[sdof_pkg::CFG_SIN] = to_q(e * $sin(wd * dt));
                    cset[sdof_pkg::CFG_COS] = to_q(e * $cos(wd * dt));
                    cset[sdof_pkg::CFG_WD] = to_q(wd);
                    cset[sdof_pkg::CFG_DW] = to_q(dw);
                    cset[sdof_pkg::CFG_W2I] = to_q(1.0 / (w * w));
                    cset[sdof_pkg::CFG_W2IDT] = to_q(1.0 / (w * w * dt));
                    cset[sdof_pkg::CFG_WDI] = to_q(1.0 / wd);
                    cset[sdof_pkg::CFG_RAMP] = to_q(2.0 * z / (dt * w * w * w));
                end
                1: foreach (cset[i])
                    cset[i] = longint'($signed($urandom)) <<< $urandom_range(3);
                2: foreach (cset[i]) cset[i] = MAXQ;
                3: foreach (cset[i]) cset[i] = MINQ;
                default: foreach (cset[i]) cset[i] = 0;
            endcase
            foreach (cset[i]) write_reg(3'(i), cset[i]);
            tx_idle = (ph < 2) ? 12 : (ph < 4) ? 65 : 0;
            rx_idle = (ph < 2) ? 65 : (ph < 4) ? 12 : 0;

            // mostly full records with random content, some lone starts as noise
            n = 0;
            while (n < 215) begin
                if ($urandom_range(9) == 0) begin
                    send_sample(1'b1, rand_sample(), 1'b0, none);
                end else begin
                    len = $urandom_range(2, 30);
                    send_sample(1'b1, rand_sample(), 1'b0, none);
                    repeat (len - 1) send_sample(1'b0, rand_sample(), 1'b0, none);
                    n += len;
                end
            end
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sdof_pkg.sv
hw/rtl/sdof_mul.sv
hw/rtl/sdof_core.sv
hw/rtl/sdof_oscillator_response_top.sv
bench/tb_top.sv
